### rtl/tsq_pkg.sv
// Shared constants, codes and types for the two-stack queue.
`timescale 1ns / 1ps

package tsq_pkg;

  // Storage geometry.
  localparam int StackDepth = 16;
  localparam int ItemW      = 32;
  localparam int AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int CntW       = $clog2(StackDepth + 1);

  // Fixed field widths.
  localparam int CapW    = 5;
  localparam int StatusW = 2;
  localparam int CountW  = 6;
  localparam int CmpW    = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // Operation codes.
  localparam logic ModeEnq = 1'b0;
  localparam logic ModeDeq = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_XFER = 5'b00100,
    S_POP  = 5'b01000,
    S_RESP = 5'b10000
  } tsq_state_e;

endpackage

### rtl/tsq_req_if.sv
// Request channel: operation and item value with valid/ready handshake.
`timescale 1ns / 1ps

interface tsq_req_if import tsq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [ItemW-1:0] item_value;

  modport source (output valid, mode, item_value, input ready);
  modport sink   (input valid, mode, item_value, output ready);
endinterface

### rtl/tsq_rsp_if.sv
// Response channel: status, dequeued value and item count with valid/ready handshake.
`timescale 1ns / 1ps

interface tsq_rsp_if import tsq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [ItemW-1:0] out_value;
  logic [CountW-1:0]       item_count;

  modport source (output valid, status, out_value, item_count, input ready);
  modport sink   (input valid, status, out_value, item_count, output ready);
endinterface

### rtl/two_stack_queue_unit.sv
// Top level: FIFO queue built from a push stack and a pop stack under a small sequencer.
`timescale 1ns / 1ps
// A plain enqueue, or a refused or empty operation, passes from the decision through S_RESP
// to the output register; a dequeue from a non-empty pop stack first reads the RAM in S_POP.
// A transfer between the stacks moves one item per cycle through the RAM ports in S_XFER,
// and the operation is then decided again in S_EXEC. One transaction is in work at a time,
// so a new one is accepted only once the sequencer is back in S_IDLE.
// Reset clears both counts and sets the capacity to 16; store contents stay undefined.

module two_stack_queue_unit import tsq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  tsq_req_if.sink         in_i,
  tsq_rsp_if.source       out_o
);

  tsq_state_e state_q, state_d;

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] push_cnt_q, push_cnt_d;
  logic [CntW-1:0] pop_cnt_q, pop_cnt_d;
  logic            pend_q, pend_d;

  logic                    mode_q;
  logic signed [ItemW-1:0] value_q;
  logic [StatusW-1:0]      res_status_q, res_status_d;
  logic signed [ItemW-1:0] res_value_q, res_value_d;

  logic                    out_valid_q, out_valid_d;
  logic [StatusW-1:0]      out_status_q;
  logic signed [ItemW-1:0] out_value_q;
  logic [CountW-1:0]       out_count_q;
  logic                    out_load;

  logic                    push_we;
  logic                    pop_we;
  logic [ItemW-1:0]        push_rdata;
  logic [ItemW-1:0]        pop_rdata;
  logic [CntW-1:0]         push_dec;
  logic [CntW-1:0]         pop_dec;

  logic                    accept;
  logic                    decide;
  logic                    cur_mode;
  logic signed [ItemW-1:0] cur_value;
  logic [CmpW-1:0]         eff_cap;
  logic                    push_full;
  logic                    out_free;
  logic [CntW:0]           total;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign decide   = accept || (state_q == S_EXEC);
  assign cur_mode  = (state_q == S_IDLE) ? in_i.mode : mode_q;
  assign cur_value = (state_q == S_IDLE) ? in_i.item_value : value_q;
  assign out_free = !out_valid_q || out_o.ready;

  assign push_dec = push_cnt_q - 1'b1;
  assign pop_dec  = pop_cnt_q - 1'b1;
  assign total    = {1'b0, push_cnt_q} + {1'b0, pop_cnt_q};

  // Effective capacity: zero acts as one, large values clamp to the stack depth.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(StackDepth)) begin
      eff_cap = CmpW'(StackDepth);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
  end

  assign push_full = CmpW'(push_cnt_q) >= eff_cap;

  // Stack storage.
  tsq_ram #(.WIDTH(ItemW), .DEPTH(StackDepth)) u_push_ram (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (push_cnt_q[AddrW-1:0]),
    .wdata_i (cur_value),
    .raddr_i (push_dec[AddrW-1:0]),
    .rdata_o (push_rdata)
  );

  tsq_ram #(.WIDTH(ItemW), .DEPTH(StackDepth)) u_pop_ram (
    .clk_i   (clk_i),
    .we_i    (pop_we),
    .waddr_i (pop_cnt_q[AddrW-1:0]),
    .wdata_i (push_rdata),
    .raddr_i (pop_dec[AddrW-1:0]),
    .rdata_o (pop_rdata)
  );

  // Sequencer: decide, transfer, pop read and result hand-off.
  always_comb begin
    state_d      = state_q;
    push_cnt_d   = push_cnt_q;
    pop_cnt_d    = pop_cnt_q;
    pend_d       = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    push_we      = 1'b0;
    pop_we       = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE, S_EXEC: begin
        if (decide) begin
          res_status_d = StatusOk;
          res_value_d  = '0;
          if (cur_mode == ModeEnq) begin
            if (push_full && (pop_cnt_q != '0)) begin
              res_status_d = StatusFull;
              state_d      = S_RESP;
            end else if (push_full) begin
              state_d = S_XFER;
            end else begin
              push_we    = 1'b1;
              push_cnt_d = push_cnt_q + 1'b1;
              state_d    = S_RESP;
            end
          end else begin
            if (total == '0) begin
              res_status_d = StatusEmpty;
              state_d      = S_RESP;
            end else if (pop_cnt_q == '0) begin
              state_d = S_XFER;
            end else begin
              pop_cnt_d = pop_dec;
              state_d   = S_POP;
            end
          end
        end
      end
      S_XFER: begin
        // Read the push top each cycle; write the previous read into the pop stack.
        if (push_cnt_q != '0) begin
          push_cnt_d = push_dec;
          pend_d     = 1'b1;
        end
        if (pend_q) begin
          pop_we    = 1'b1;
          pop_cnt_d = pop_cnt_q + 1'b1;
        end
        if ((push_cnt_q == '0) && !pend_q) begin
          state_d = S_EXEC;
        end
      end
      S_POP: begin
        res_value_d = pop_rdata;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid tracking.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CapReset;
      push_cnt_q  <= '0;
      pop_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      push_cnt_q  <= push_cnt_d;
      pop_cnt_q   <= pop_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_i.mode;
      value_q <= in_i.item_value;
    end
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= CountW'(total);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_value  = out_value_q;
  assign out_o.item_count = out_count_q;

`ifndef SYNTHESIS
  // Neither stack count ever passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_q <= CntW'(StackDepth)) && (pop_cnt_q <= CntW'(StackDepth)))
    else $error("stack count above depth");

  // A pending transfer read lands in the pop stack on the next cycle.
  a_xfer_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XFER && pend_q) |=> (pop_cnt_q == $past(pop_cnt_q) + 1'b1))
    else $error("transfer did not advance pop stack");

  // An empty result reports no items and a zero value.
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StatusEmpty) |->
      (out_count_q == '0 && out_value_q == '0))
    else $error("empty result with nonzero count or value");
`endif

endmodule

### rtl/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sim/two_stack_queue_unit_tb.sv
// Self-checking testbench for the two-stack queue unit with a scoreboard of predicted results.
`timescale 1ns / 1ps

module two_stack_queue_unit_tb import tsq_pkg::*;;

  // One predicted or observed response transaction.
  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [ItemW-1:0] out_value;
    logic [CountW-1:0]       item_count;
  } queue_result_t;

  logic            clk;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CapW-1:0] cfg_wdata_i;

  tsq_req_if req_if ();
  tsq_rsp_if rsp_if ();

  two_stack_queue_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // Shadow copy of the two stacks and the capacity register.
  logic signed [ItemW-1:0] push_mem [StackDepth];
  logic signed [ItemW-1:0] pop_mem  [StackDepth];
  int                      push_depth = 0;
  int                      pop_depth  = 0;
  logic [CapW-1:0]         cap_reg    = CapReset;

  // Results still owed by the block, oldest first.
  queue_result_t pending_results [$];
  int            error_count    = 0;

  // Idling controls shared by the sender, the receiver and the tests.
  bit tx_steady      = 1'b0;
  bit rx_steady      = 1'b0;
  int rx_hold_cycles = 0;

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Move every entry of the push stack onto the pop stack, reversing the order.
  function automatic void move_push_to_pop();
    while (push_depth > 0 && pop_depth < StackDepth) begin
      push_depth--;
      pop_mem[pop_depth] = push_mem[push_depth];
      pop_depth++;
    end
  endfunction

  // Apply one operation to the shadow queue and return the response it must produce.
  function automatic queue_result_t predict_queue_op(input logic op,
                                                     input logic signed [ItemW-1:0] val);
    queue_result_t res;
    int            cap;
    res.status    = StatusOk;
    res.out_value = '0;
    cap = int'(cap_reg);
    if (cap < 1) cap = 1;
    if (cap > StackDepth) cap = StackDepth;
    if (op == ModeEnq) begin
      if (push_depth >= cap && pop_depth != 0) begin
        res.status = StatusFull;
      end else begin
        if (push_depth >= cap) move_push_to_pop();
        if (push_depth < StackDepth) begin
          push_mem[push_depth] = val;
          push_depth++;
        end else begin
          res.status = StatusFull;
        end
      end
    end else if (push_depth + pop_depth == 0) begin
      res.status = StatusEmpty;
    end else begin
      if (pop_depth == 0) move_push_to_pop();
      pop_depth--;
      res.out_value = pop_mem[pop_depth];
    end
    res.item_count = CountW'(push_depth + pop_depth);
    return res;
  endfunction

  // Offer one request after a random gap unless tx_steady is set; record its prediction on acceptance.
  task automatic send_queue_op(input logic op, input logic signed [ItemW-1:0] val);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= op;
    req_if.item_value <= val;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_queue_op(op, val));
  endtask

  // Stop offering and wait until every predicted response has been checked.
  task automatic wait_queue_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register while the block is idle.
  task automatic set_capacity(input logic [CapW-1:0] cap);
    wait_queue_idle();
    cfg_wdata_i <= cap;
    cfg_we_i    <= 1'b1;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
    cap_reg = cap;
  endtask

  // Report one wrong response field; only the first ten are printed.
  task automatic report_field(input string name, input logic [ItemW-1:0] want,
                              input logic [ItemW-1:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %0s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Receiver: stalls a random number of cycles per response unless rx_steady is set, or a long hold-off on request.
  initial begin : result_sink
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: unexpected response status=%0h value=%0h count=%0d", $realtime,
                   rsp_if.status, rsp_if.out_value, rsp_if.item_count);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_field("status", want.status, rsp_if.status);
        if (rsp_if.out_value !== want.out_value)
          report_field("out_value", want.out_value, rsp_if.out_value);
        if (rsp_if.item_count !== want.item_count)
          report_field("item_count", want.item_count, rsp_if.item_count);
      end
    end
  end

  // Reset capacity: empty dequeue and the extreme item values in order.
  task automatic test_empty_and_extremes();
    send_queue_op(ModeDeq, $urandom);
    send_queue_op(ModeEnq, 32'sh8000_0000);
    send_queue_op(ModeEnq, 32'sh7fff_ffff);
    send_queue_op(ModeEnq, 32'sh0000_0000);
    send_queue_op(ModeEnq, -32'sd1);
    send_queue_op(ModeEnq, 32'sh5555_5555);
    send_queue_op(ModeEnq, 32'shaaaa_aaaa);
    repeat (6) send_queue_op(ModeDeq, $urandom);
    send_queue_op(ModeDeq, $urandom);
  endtask

  // A capacity of zero acts as one: transfer on enqueue, refusal, transfer on dequeue.
  task automatic test_capacity_zero();
    set_capacity(CapW'(0));
    send_queue_op(ModeEnq, $urandom);
    send_queue_op(ModeEnq, $urandom);
    send_queue_op(ModeEnq, $urandom);
    send_queue_op(ModeDeq, $urandom);
    send_queue_op(ModeDeq, $urandom);
  endtask

  // Lowering the capacity below the held count keeps the items and forces a transfer.
  task automatic test_capacity_lowered();
    set_capacity(CapW'(16));
    repeat (3) send_queue_op(ModeEnq, $urandom);
    set_capacity(CapW'(1));
    send_queue_op(ModeEnq, $urandom);
    send_queue_op(ModeEnq, $urandom);
    send_queue_op(ModeDeq, $urandom);
  endtask

  // Fill both stacks to the full depth, get refused, then drain past empty.
  task automatic test_fill_and_drain();
    set_capacity(CapW'(16));
    while (push_depth + pop_depth > 0) send_queue_op(ModeDeq, $urandom);
    repeat (2 * StackDepth + 1) send_queue_op(ModeEnq, $urandom);
    repeat (2 * StackDepth + 1) send_queue_op(ModeDeq, $urandom);
  endtask

  // Random operation mixes under a series of capacities, extremes included.
  task automatic test_random_phases();
    logic [CapW-1:0] caps [10];
    int              enq_weight;
    caps = '{CapW'(16), CapW'(1), CapW'(2), CapW'(3), CapW'(0),
             CapW'(31), CapW'(8), CapW'(5), CapW'(17), CapW'($urandom_range(0, 31))};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      tx_steady = (p == 3);
      rx_steady = (p == 3) || (p == 7);
      for (int chunk = 0; chunk < 15; chunk++) begin
        enq_weight = $urandom_range(15, 85);
        for (int k = 0; k < 10; k++) begin
          if ($urandom_range(0, 99) < enq_weight) send_queue_op(ModeEnq, $urandom);
          else send_queue_op(ModeDeq, $urandom);
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering back to back.
  task automatic test_backpressure();
    set_capacity(CapW'(4));
    rx_hold_cycles = 150;
    tx_steady      = 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_queue_op(($urandom_range(0, 99) < 60) ? ModeEnq : ModeDeq, $urandom);
    end
    tx_steady = 1'b0;
    wait_queue_idle();
  endtask

  // Test sequence and final verdict.
  initial begin : test_sequence
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= CapReset;
    req_if.valid      <= 1'b0;
    req_if.mode       <= ModeEnq;
    req_if.item_value <= '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_capacity_zero();
    test_capacity_lowered();
    test_fill_and_drain();
    test_random_phases();
    test_backpressure();

    // Let the last responses arrive, bounded in case the block hangs.
    req_if.valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### two_stack_queue_unit.f
rtl/tsq_pkg.sv
rtl/tsq_req_if.sv
rtl/tsq_rsp_if.sv
rtl/tsq_ram.sv
rtl/two_stack_queue_unit.sv
sim/two_stack_queue_unit_tb.sv
